>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue: the request and
// response transaction formats, status codes and the cell command group.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned TAG_W   = 16;
   localparam int unsigned AGE_W   = 8;
   localparam int unsigned COND_W  = 2;
   localparam int unsigned PRIO_W  = 3;
   localparam int unsigned TOTAL_W = 5;

   typedef enum logic [0:0] {
      REQ_INSERT = 1'b0,
      REQ_POP    = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      req_kind_type        req_type;
      logic [TAG_W-1:0]    rec_tag;
      logic [AGE_W-1:0]    rec_age;
      logic [COND_W-1:0]   rec_condition;
      logic [PRIO_W-1:0]   rec_priority;
   } req_payload_type;

   typedef struct packed {
      status_type          status;
      logic [TAG_W-1:0]    out_tag;
      logic [AGE_W-1:0]    out_age;
      logic [COND_W-1:0]   out_condition;
      logic [PRIO_W-1:0]   out_priority;
      logic [TOTAL_W-1:0]  entry_total;
      logic                head_valid;
      logic [TAG_W-1:0]    head_tag;
   } rsp_payload_type;

   // Fixed-width part of one stored record; the tag travels separately
   // because its width is a parameter of the top level.
   typedef struct packed {
      logic [PRIO_W-1:0]   priority_val;
      logic [AGE_W-1:0]    age;
      logic [COND_W-1:0]   condition;
   } slot_info_type;

   // Command group broadcast to every cell, plus the per-cell neighbor view.
   typedef struct packed {
      logic                insert;
      logic                pop;
      logic                occupied;
      logic                left_stay;
   } cell_cmd_type;

endpackage

>>> design/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable priority queue built as a row of shifting cells. Inserts
// land behind every record of equal or higher priority; pops take the head.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Contents
//   request   in         start high, busy low     req_data (insert or pop)
//   response  out        rsp_valid, one cycle     rsp_data (status, record,
//                                                 count and head after it)
//
// Every request transaction yields exactly one response transaction, shown
// on rsp_valid and rsp_data in the cycle after the request is taken, so the
// queue takes one request per cycle. All cells decide in parallel from
// their own priority compare and their left neighbor's, so the response
// does not depend on the fill level. busy is always low: the receiver
// cannot stall and no request ever holds off the next one.
// Synchronous reset empties the queue by clearing the record count; slot
// contents are left as they are and are never read until written.
// ----------------------------------------------------------------------------
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned TAG_BITS    = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff;
   rsp_payload_type     rsp_in;

   logic                accept;
   logic                queue_full;
   logic                queue_empty;
   logic                insert_ok;
   logic                pop_ok;
   logic [TAG_BITS-1:0] new_tag;
   slot_info_type       new_info;
   logic [TAG_BITS-1:0] head_tag_next;

   logic [TAG_BITS-1:0] cell_tag  [QUEUE_DEPTH];
   slot_info_type       cell_info [QUEUE_DEPTH];
   logic                cell_stay [QUEUE_DEPTH];

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign insert_ok   = accept && (req_data.req_type == REQ_INSERT) && !queue_full;
   assign pop_ok      = accept && (req_data.req_type == REQ_POP) && !queue_empty;

   // The size cast keeps the low TAG_BITS bits or zero-extends as needed.
   assign new_tag               = TAG_BITS'(req_data.rec_tag);
   assign new_info.priority_val = req_data.rec_priority;
   assign new_info.age          = req_data.rec_age;
   assign new_info.condition    = req_data.rec_condition;

   // The chain: cell 0 is the head. A cell shifts toward the tail on insert
   // when its left neighbor gave up its place, and toward the head on pop.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_cmd_type        cmd;
      logic [TAG_BITS-1:0] left_tag;
      slot_info_type       left_info;
      logic [TAG_BITS-1:0] right_tag;
      slot_info_type       right_info;

      assign cmd.insert   = insert_ok;
      assign cmd.pop      = pop_ok;
      assign cmd.occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign cmd.left_stay = 1'b1;
         assign left_tag      = new_tag;
         assign left_info     = new_info;
      end else begin : g_body
         assign cmd.left_stay = cell_stay[i-1];
         assign left_tag      = cell_tag[i-1];
         assign left_info     = cell_info[i-1];
      end

      // The tail cell has nothing behind it; what it takes on a pop is
      // beyond the new count and is never read.
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_tag  = cell_tag[i];
         assign right_info = cell_info[i];
      end else begin : g_inner
         assign right_tag  = cell_tag[i+1];
         assign right_info = cell_info[i+1];
      end

      spq_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock        (clock),
         .cmd          (cmd),
         .new_priority (req_data.rec_priority),
         .new_tag      (new_tag),
         .new_info     (new_info),
         .left_tag     (left_tag),
         .left_info    (left_info),
         .right_tag    (right_tag),
         .right_info   (right_info),
         .stay         (cell_stay[i]),
         .tag          (cell_tag[i]),
         .info         (cell_info[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (insert_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Head tag after this transaction, mirrored from what cell 0 will load.
   always_comb begin
      head_tag_next = cell_tag[0];
      if (insert_ok && !cell_stay[0]) begin
         head_tag_next = new_tag;
      end else if (pop_ok) begin
         head_tag_next = cell_tag[1];
      end
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = STATUS_OK;
      if (req_data.req_type == REQ_INSERT) begin
         if (queue_full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else if (queue_empty) begin
         rsp_in.status = STATUS_EMPTY;
      end else begin
         rsp_in.out_tag       = TAG_W'(cell_tag[0]);
         rsp_in.out_age       = cell_info[0].age;
         rsp_in.out_condition = cell_info[0].condition;
         rsp_in.out_priority  = cell_info[0].priority_val;
      end
      rsp_in.entry_total = TOTAL_W'(count_in);
      rsp_in.head_valid  = (count_in != '0);
      rsp_in.head_tag    = (count_in != '0) ? TAG_W'(head_tag_next) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue. It holds a record, reports whether it keeps
// its place for the incoming priority, and takes a record from either
// neighbor or from the request when the queue shifts.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
#(
   parameter int unsigned TAG_BITS = 16
) (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [PRIO_W-1:0]   new_priority,
   input  logic [TAG_BITS-1:0] new_tag,
   input  slot_info_type       new_info,
   input  logic [TAG_BITS-1:0] left_tag,
   input  slot_info_type       left_info,
   input  logic [TAG_BITS-1:0] right_tag,
   input  slot_info_type       right_info,
   output logic                stay,
   output logic [TAG_BITS-1:0] tag,
   output slot_info_type       info
);

   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   slot_info_type       info_ff;
   slot_info_type       info_in;

   // A stored record of equal or higher priority stays ahead of the newcomer.
   assign stay = cmd.occupied && (info_ff.priority_val >= new_priority);

   always_comb begin
      tag_in  = tag_ff;
      info_in = info_ff;
      if (cmd.insert && !stay) begin
         if (cmd.left_stay) begin
            tag_in  = new_tag;
            info_in = new_info;
         end else begin
            tag_in  = left_tag;
            info_in = left_info;
         end
      end else if (cmd.pop) begin
         tag_in  = right_tag;
         info_in = right_info;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      info_ff <= info_in;
   end

   assign tag  = tag_ff;
   assign info = info_ff;

endmodule
